FILE: sv/qp2m_pkg.sv
// ----------------------------------------------------------------------------
// qp2m_pkg
// shared types and constants for the pose to transform block
// ----------------------------------------------------------------------------
package qp2m_pkg;

   localparam int QUAT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int TRANS_W       = 32;
   localparam int QIN_W         = 16;
   localparam int ENTRY_W       = 32;
   localparam int N_ENTRY       = 9;
   localparam int QUEUE_DEPTH   = 2;

   typedef struct packed {
      logic signed [TRANS_W-1:0] trans_x;
      logic signed [TRANS_W-1:0] trans_y;
      logic signed [TRANS_W-1:0] trans_z;
      logic signed [QIN_W-1:0]   quat_x;
      logic signed [QIN_W-1:0]   quat_y;
      logic signed [QIN_W-1:0]   quat_z;
      logic signed [QIN_W-1:0]   quat_w;
   } req_type;

   typedef struct packed {
      logic [1:0]                column_index;
      logic signed [ENTRY_W-1:0] row_zero;
      logic signed [ENTRY_W-1:0] row_one;
      logic signed [ENTRY_W-1:0] row_two;
      logic                      pose_valid;
      logic                      is_last;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   localparam logic [1:0] COL_TRANS = 2'd3;

endpackage

FILE: sv/qp2m_queue.sv
// ----------------------------------------------------------------------------
// qp2m_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module qp2m_queue
   import qp2m_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/qp2m_front.sv
// ----------------------------------------------------------------------------
// qp2m_front
// accepts poses, forms products, norm and signed numerators
// ----------------------------------------------------------------------------
module qp2m_front
   import qp2m_pkg::*;
#(
   parameter int QUAT_BITS = QUAT_BITS_DEF,
   parameter int JOB_W     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             push,
   output logic [JOB_W-1:0] push_data,
   input  logic             full
);

   localparam int QB = QUAT_BITS;
   localparam int PW = 2*QB;
   localparam int SW = 2*QB + 1;
   localparam int DW = 2*QB + 2;
   localparam int MW = 2*QB + 1;

   logic                 v_ff, v_in;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   logic signed [TRANS_W-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [QB-1:0] x, y, z, w;
   logic signed [31:0]   ex, ey, ez, ew;
   logic                 accept;

   logic signed [DW-1:0] d [N_ENTRY];
   logic [N_ENTRY-1:0][MW-1:0] mag;
   logic [N_ENTRY-1:0]   neg;
   logic [SW-1:0]        s;
   logic                 nz;

   // sign extension from QIN_W bits, then the low QUAT_BITS bits are kept
   assign ex = 32'(req_data.quat_x);
   assign ey = 32'(req_data.quat_y);
   assign ez = 32'(req_data.quat_z);
   assign ew = 32'(req_data.quat_w);
   assign x  = ex[QB-1:0];
   assign y  = ey[QB-1:0];
   assign z  = ez[QB-1:0];
   assign w  = ew[QB-1:0];

   assign req_stall = v_ff && full;
   assign accept    = req_valid && !req_stall;
   assign push      = v_ff && !full;

   always_comb begin
      v_in = v_ff;
      if (accept) begin
         v_in = 1'b1;
      end else if (push) begin
         v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         xx_ff <= x * x;
         yy_ff <= y * y;
         zz_ff <= z * z;
         ww_ff <= w * w;
         xy_ff <= x * y;
         zw_ff <= z * w;
         xz_ff <= x * z;
         yw_ff <= y * w;
         yz_ff <= y * z;
         xw_ff <= x * w;
         tx_ff <= req_data.trans_x;
         ty_ff <= req_data.trans_y;
         tz_ff <= req_data.trans_z;
      end
   end

   // entry e = column*3 + row; off-diagonal terms doubled
   always_comb begin
      s    = SW'(unsigned'(xx_ff)) + SW'(unsigned'(yy_ff))
           + SW'(unsigned'(zz_ff)) + SW'(unsigned'(ww_ff));
      nz   = (s != '0);
      d[0] = DW'(xx_ff) + DW'(ww_ff) - DW'(yy_ff) - DW'(zz_ff);
      d[1] = (DW'(xy_ff) + DW'(zw_ff)) <<< 1;
      d[2] = (DW'(xz_ff) - DW'(yw_ff)) <<< 1;
      d[3] = (DW'(xy_ff) - DW'(zw_ff)) <<< 1;
      d[4] = DW'(yy_ff) + DW'(ww_ff) - DW'(xx_ff) - DW'(zz_ff);
      d[5] = (DW'(yz_ff) + DW'(xw_ff)) <<< 1;
      d[6] = (DW'(xz_ff) + DW'(yw_ff)) <<< 1;
      d[7] = (DW'(yz_ff) - DW'(xw_ff)) <<< 1;
      d[8] = DW'(zz_ff) + DW'(ww_ff) - DW'(xx_ff) - DW'(yy_ff);
      for (int e = 0; e < N_ENTRY; e++) begin
         neg[e] = d[e][DW-1];
         mag[e] = neg[e] ? MW'(-d[e]) : MW'(d[e]);
      end
   end

   assign push_data = {tz_ff, ty_ff, tx_ff, nz, s, mag, neg};

endmodule

FILE: sv/qp2m_back.sv
// ----------------------------------------------------------------------------
// qp2m_back
// nine bit-serial rounding dividers and the column sequencer
// ----------------------------------------------------------------------------
module qp2m_back
   import qp2m_pkg::*;
#(
   parameter int QUAT_BITS = QUAT_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int JOB_W     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  logic [JOB_W-1:0] pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int SW = 2*QUAT_BITS + 1;
   localparam int MW = 2*QUAT_BITS + 1;
   localparam int FB = FRAC_BITS;
   localparam int QW = FB + 1;
   localparam int NW = MW + FB + 2;
   localparam int CW = $clog2(QW + 1);

   back_state_type state_ff, state_in;

   logic signed [TRANS_W-1:0] tz, ty, tx;
   logic                      nz;
   logic [SW-1:0]             s;
   logic [N_ENTRY-1:0][MW-1:0] mag;
   logic [N_ENTRY-1:0]        neg;

   logic [NW-1:0]  rem_ff [N_ENTRY];
   logic [NW-1:0]  rem_in [N_ENTRY];
   logic [QW-1:0]  q_ff   [N_ENTRY];
   logic [QW-1:0]  q_in   [N_ENTRY];
   logic [NW-1:0]  d_ff, d_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [1:0]     col_ff, col_in;
   logic [N_ENTRY-1:0] neg_ff, neg_in;
   logic           nz_ff, nz_in;
   logic signed [TRANS_W-1:0] tx_ff, ty_ff, tz_ff, tx_in, ty_in, tz_in;

   logic           ov_ff, ov_in;
   rsp_type        od_ff, od_in;
   logic           out_free;
   logic signed [ENTRY_W-1:0] val [N_ENTRY];

   assign {tz, ty, tx, nz, s, mag, neg} = pop_data;
   assign out_free  = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;

   always_comb begin
      for (int e = 0; e < N_ENTRY; e++) begin
         val[e] = neg_ff[e] ? -ENTRY_W'(q_ff[e]) : ENTRY_W'(q_ff[e]);
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      neg_in   = neg_ff;
      nz_in    = nz_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      tz_in    = tz_ff;
      ov_in    = ov_ff && rsp_stall;
      od_in    = od_ff;
      for (int e = 0; e < N_ENTRY; e++) begin
         rem_in[e] = rem_ff[e];
         q_in[e]   = q_ff[e];
      end
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               d_in   = NW'(s) << (FB + 1);
               cnt_in = '0;
               neg_in = neg;
               nz_in  = nz;
               tx_in  = tx;
               ty_in  = ty;
               tz_in  = tz;
               for (int e = 0; e < N_ENTRY; e++) begin
                  // numerator mag * 2^(FB+1) + s, divisor 2s
                  rem_in[e] = (NW'(mag[e]) << (FB + 1)) + NW'(s);
                  q_in[e]   = '0;
               end
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            for (int e = 0; e < N_ENTRY; e++) begin
               if (rem_ff[e] >= d_ff) begin
                  rem_in[e] = rem_ff[e] - d_ff;
                  q_in[e]   = {q_ff[e][QW-2:0], 1'b1};
               end else begin
                  q_in[e]   = {q_ff[e][QW-2:0], 1'b0};
               end
            end
            d_in   = d_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               col_in   = '0;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               ov_in              = 1'b1;
               od_in.column_index = col_ff;
               od_in.pose_valid   = nz_ff;
               od_in.is_last      = (col_ff == COL_TRANS);
               case (col_ff)
                  2'd0: begin
                     od_in.row_zero = val[0];
                     od_in.row_one  = val[1];
                     od_in.row_two  = val[2];
                  end
                  2'd1: begin
                     od_in.row_zero = val[3];
                     od_in.row_one  = val[4];
                     od_in.row_two  = val[5];
                  end
                  2'd2: begin
                     od_in.row_zero = val[6];
                     od_in.row_one  = val[7];
                     od_in.row_two  = val[8];
                  end
                  default: begin
                     od_in.row_zero = tx_ff;
                     od_in.row_one  = ty_ff;
                     od_in.row_two  = tz_ff;
                  end
               endcase
               if (!nz_ff) begin
                  od_in.row_zero = '0;
                  od_in.row_one  = '0;
                  od_in.row_two  = '0;
               end
               col_in = col_ff + 1'b1;
               if (col_ff == COL_TRANS) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      col_ff <= col_in;
      neg_ff <= neg_in;
      nz_ff  <= nz_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
      tz_ff  <= tz_in;
      od_ff  <= od_in;
      for (int e = 0; e < N_ENTRY; e++) begin
         rem_ff[e] <= rem_in[e];
         q_ff[e]   <= q_in[e];
      end
   end

endmodule

FILE: sv/quaternion_pose_to_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_pose_to_matrix
// pose (translation + raw quaternion) to column-major homogeneous transform
// ----------------------------------------------------------------------------
// each accepted pose gives four items on rsp: rotation columns 0..2 and then
// the translation column, is_last on the fourth. rotation entries are the
// exact ratios of the normalized quaternion in signed q(FRAC_BITS), rounded
// to nearest with ties away from zero; a zero quaternion gives pose_valid 0
// and all entries zero. the front registers the ten products, forms the norm
// and nine signed numerators and hands a job to a two-entry queue; the back
// runs nine restoring dividers side by side, one quotient bit per cycle, and
// then sends the four columns through an output register. the back takes
// one pose at a time, from the pop through the divide to the last column;
// the front takes a new pose while the back is busy until the queue fills.
// a pose goes from the front product registers through the queue memory
// into the back divider registers and then to the output register.
// ----------------------------------------------------------------------------
module quaternion_pose_to_matrix
   import qp2m_pkg::*;
#(
   parameter int QUAT_BITS = QUAT_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // job: translation, nonzero flag, norm, nine magnitudes, nine signs
   localparam int SW    = 2*QUAT_BITS + 1;
   localparam int MW    = 2*QUAT_BITS + 1;
   localparam int JOB_W = 3*TRANS_W + 1 + SW + N_ENTRY*MW + N_ENTRY;

   logic             push, pop, full, empty;
   logic [JOB_W-1:0] push_data, pop_data;

   qp2m_front #(
      .QUAT_BITS (QUAT_BITS),
      .JOB_W     (JOB_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // decouples product stage from the dividers
   qp2m_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   qp2m_back #(
      .QUAT_BITS (QUAT_BITS),
      .FRAC_BITS (FRAC_BITS),
      .JOB_W     (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
